// ===== sv/tccf_pkg.sv =====
package tccf_pkg;

    localparam int FRAME_BYTES_DEF  = 63;
    localparam int QUEUE_FRAMES_DEF = 4;

    // Codes of the action field.
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_MSG     = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;
    localparam logic [1:0] ACT_OFF     = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_CRAFT_ID  = 3'd0;
    localparam logic [2:0] REG_VERSION   = 3'd1;
    localparam logic [2:0] REG_RANDOMIZE = 3'd2;
    localparam logic [2:0] REG_SINE_LEN  = 3'd3;
    localparam logic [2:0] REG_ACQ_LEN   = 3'd4;

    // Link phases.
    localparam logic [1:0] PH_SINE = 2'd0;
    localparam logic [1:0] PH_ACQ  = 2'd1;
    localparam logic [1:0] PH_IDLE = 2'd2;
    localparam logic [1:0] PH_OFF  = 2'd3;

    localparam logic [7:0] BYTE_SYNC0   = 8'heb;
    localparam logic [7:0] BYTE_SYNC1   = 8'h90;
    localparam logic [7:0] BYTE_TAIL    = 8'hc5;
    localparam logic [7:0] BYTE_TAIL_END = 8'h79;
    localparam logic [7:0] BYTE_IDLE    = 8'h55;
    localparam logic [7:0] PARITY_MASK  = 8'hfe;
    localparam logic [7:0] BCH_POLY     = 8'h8a;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_dropped;
    } out_word_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        logic       is_tick;
        logic       is_msg;
        logic       is_restart;
        logic       is_off;
        logic [7:0] data_byte;
        logic       last_byte;
    } cmd_t;

    localparam logic [7:0] PN_SEQ [0:254] = '{
        8'hff,8'h39,8'h9e,8'h5a,8'h68,8'he9,8'h06,8'hf5,8'h6c,8'h89,8'h2f,8'ha1,8'h31,8'h5e,
        8'h08,8'hc0,8'h52,8'ha8,8'hbb,8'hae,8'h4e,8'hc2,8'hc7,8'hed,8'h66,8'hdc,8'h38,8'hd4,
        8'hf8,8'h86,8'h50,8'h3d,8'hfe,8'h73,8'h3c,8'hb4,8'hd1,8'hd2,8'h0d,8'hea,8'hd9,8'h12,
        8'h5f,8'h42,8'h62,8'hbc,8'h11,8'h80,8'ha5,8'h51,8'h77,8'h5c,8'h9d,8'h85,8'h8f,8'hda,
        8'hcd,8'hb8,8'h71,8'ha9,8'hf1,8'h0c,8'ha0,8'h7b,8'hfc,8'he6,8'h79,8'h69,8'ha3,8'ha4,
        8'h1b,8'hd5,8'hb2,8'h24,8'hbe,8'h84,8'hc5,8'h78,8'h23,8'h01,8'h4a,8'ha2,8'hee,8'hb9,
        8'h3b,8'h0b,8'h1f,8'hb5,8'h9b,8'h70,8'he3,8'h53,8'he2,8'h19,8'h40,8'hf7,8'hf9,8'hcc,
        8'hf2,8'hd3,8'h47,8'h48,8'h37,8'hab,8'h64,8'h49,8'h7d,8'h09,8'h8a,8'hf0,8'h46,8'h02,
        8'h95,8'h45,8'hdd,8'h72,8'h76,8'h16,8'h3f,8'h6b,8'h36,8'he1,8'hc6,8'ha7,8'hc4,8'h32,
        8'h81,8'hef,8'hf3,8'h99,8'he5,8'ha6,8'h8e,8'h90,8'h6f,8'h56,8'hc8,8'h92,8'hfa,8'h13,
        8'h15,8'he0,8'h8c,8'h05,8'h2a,8'h8b,8'hba,8'he4,8'hec,8'h2c,8'h7e,8'hd6,8'h6d,8'hc3,
        8'h8d,8'h4f,8'h88,8'h65,8'h03,8'hdf,8'he7,8'h33,8'hcb,8'h4d,8'h1d,8'h20,8'hde,8'had,
        8'h91,8'h25,8'hf4,8'h26,8'h2b,8'hc1,8'h18,8'h0a,8'h55,8'h17,8'h75,8'hc9,8'hd8,8'h58,
        8'hfd,8'hac,8'hdb,8'h87,8'h1a,8'h9f,8'h10,8'hca,8'h07,8'hbf,8'hce,8'h67,8'h96,8'h9a,
        8'h3a,8'h41,8'hbd,8'h5b,8'h22,8'h4b,8'he8,8'h4c,8'h57,8'h82,8'h30,8'h14,8'haa,8'h2e,
        8'heb,8'h93,8'hb0,8'hb1,8'hfb,8'h59,8'hb7,8'h0e,8'h35,8'h3e,8'h21,8'h94,8'h0f,8'h7f,
        8'h9c,8'hcf,8'h2d,8'h34,8'h74,8'h83,8'h7a,8'hb6,8'h44,8'h97,8'hd0,8'h98,8'haf,8'h04,
        8'h60,8'h29,8'h54,8'h5d,8'hd7,8'h27,8'h61,8'h63,8'hf6,8'hb3,8'h6e,8'h1c,8'h6a,8'h7c,
        8'h43,8'h28,8'h1e
    };

    // One byte through the BCH(63,56) parity shift register, MSB first.
    function automatic logic [7:0] feed_parity(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] a;
        logic       fb;
        a = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = a[7] ^ b[k];
            a  = {a[6:0], 1'b0};
            if (fb)
            begin
                a = a ^ BCH_POLY;
            end
        end
        return a;
    endfunction

endpackage

// ===== sv/tccf_ram.sv =====
module tccf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 252
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/tccf_fifo.sv =====
module tccf_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             rd,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);
    // Two-entry queue with a combinational head.
    logic [WIDTH-1:0] slot_reg [0:1];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             do_wr, do_rd;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rdata = slot_reg[rp_reg];
    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= ~wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end
endmodule

// ===== sv/tccf_front.sv =====
module tccf_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tccf_pkg::in_word_t item,
    output logic              full,
    input  logic              cmd_take,
    output tccf_pkg::cmd_t    cmd,
    output logic              cmd_empty
);
    import tccf_pkg::*;

    cmd_t cls;

    // Decode the action once so the back sees one-hot operations.
    always_comb
    begin
        cls           = '0;
        cls.data_byte = item.data_byte;
        cls.last_byte = item.last_byte;
        case (item.action)
            ACT_TICK:    cls.is_tick    = 1'b1;
            ACT_MSG:     cls.is_msg     = 1'b1;
            ACT_RESTART: cls.is_restart = 1'b1;
            ACT_OFF:     cls.is_off     = 1'b1;
            default:     cls.is_off     = 1'b1;
        endcase
    end

    tccf_fifo #(.WIDTH($bits(cmd_t))) u_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (cls),
        .rd    (cmd_take),
        .rdata (cmd),
        .full  (full),
        .empty (cmd_empty)
    );
endmodule

// ===== sv/tccf_back.sv =====
module tccf_back #(
    parameter int FRAME_BYTES  = tccf_pkg::FRAME_BYTES_DEF,
    parameter int QUEUE_FRAMES = tccf_pkg::QUEUE_FRAMES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tccf_pkg::cmd_t     cmd,
    input  logic               cmd_empty,
    output logic               cmd_take,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               pop,
    output tccf_pkg::out_word_t result,
    output logic               empty
);
    import tccf_pkg::*;

    localparam int PAY      = FRAME_BYTES - 3;
    localparam int CB       = (FRAME_BYTES + 6) / 7;
    localparam int CLTU_LEN = 2 + 8 * CB + 8;
    localparam int PW       = $clog2(CLTU_LEN + 1);
    localparam int DW       = PW + 1;
    localparam int QW       = (QUEUE_FRAMES > 1) ? $clog2(QUEUE_FRAMES) : 1;
    localparam int CW       = $clog2(QUEUE_FRAMES + 1);
    localparam int DEPTH    = QUEUE_FRAMES * PAY;
    localparam int AW       = $clog2(DEPTH);

    // Configuration.
    logic [15:0] craft_id_reg, sine_len_reg, acq_len_reg;
    logic [3:0]  version_reg;
    logic        rnd_reg;

    // Link and queue state.
    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    fill_reg, fill_next;
    logic          blk_reg, blk_next;
    logic [1:0]    phase_reg, phase_next;
    logic [15:0]   pcnt_reg, pcnt_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    par_reg, par_next;

    // Per-slot header fields and payload length.
    logic [7:0]  len_reg [0:QUEUE_FRAMES-1];
    logic [15:0] cid_reg [0:QUEUE_FRAMES-1];
    logic [3:0]  ver_reg [0:QUEUE_FRAMES-1];

    logic        go, out_full, slot_wr;
    out_word_t   res;
    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_rdata;

    logic [DW-1:0] idx, k, d, idx_n, k_n, d_n;
    logic [7:0]    v, fbyte, acc;
    logic [16:0]   pinc;
    logic [1:0]    ph;
    logic          blk_eff;
    logic [7:0]    fill_inc;

    assign go       = !cmd_empty && !out_full;
    assign cmd_take = go;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fill_next  = fill_reg;
        blk_next   = blk_reg;
        phase_next = phase_reg;
        pcnt_next  = pcnt_reg;
        pos_next   = pos_reg;
        par_next   = par_reg;
        res        = '0;
        mem_we     = 1'b0;
        slot_wr    = 1'b0;
        mem_waddr  = AW'(tail_reg) * AW'(PAY) + AW'(fill_reg);
        idx        = DW'(pos_reg) - DW'(1);
        k          = idx - DW'(2);
        d          = DW'(k[DW-1:3]) * DW'(7) + DW'(k[2:0]);
        v          = BYTE_IDLE;
        fbyte      = 8'h00;
        acc        = 8'h00;
        pinc       = 17'(pcnt_reg) + 17'd1;
        ph         = phase_reg;
        blk_eff    = blk_reg || (count_reg >= CW'(QUEUE_FRAMES));
        fill_inc   = (fill_reg < 8'(PAY)) ? fill_reg + 8'd1 : fill_reg;

        if (go && cmd.is_tick)
        begin
            res.byte_valid = 1'b1;
            if (pos_reg != '0)
            begin
                if (idx == '0)
                begin
                    v = BYTE_SYNC0;
                end
                else if (idx == DW'(1))
                begin
                    v = BYTE_SYNC1;
                end
                else if (k >= DW'(8 * CB))
                begin
                    v = (k - DW'(8 * CB) < DW'(7)) ? BYTE_TAIL : BYTE_TAIL_END;
                end
                else if (k[2:0] == 3'd7)
                begin
                    v        = ~par_reg & PARITY_MASK;
                    par_next = 8'h00;
                end
                else
                begin
                    acc = (k[2:0] == 3'd0) ? 8'h00 : par_reg;
                    if (d < DW'(FRAME_BYTES))
                    begin
                        if (d == DW'(0))
                        begin
                            fbyte = cid_reg[head_reg][7:0];
                        end
                        else if (d == DW'(1))
                        begin
                            fbyte = cid_reg[head_reg][15:8];
                        end
                        else if (d == DW'(2))
                        begin
                            fbyte = {4'h2, ver_reg[head_reg]};
                        end
                        else if (d - DW'(3) < DW'(len_reg[head_reg]))
                        begin
                            fbyte = mem_rdata;
                        end
                        v = rnd_reg ? (fbyte ^ PN_SEQ[8'(d)]) : fbyte;
                    end
                    par_next = feed_parity(acc, v);
                end
                if (idx + DW'(1) >= DW'(CLTU_LEN))
                begin
                    pos_next = '0;
                    if (count_reg != '0)
                    begin
                        head_next  = (head_reg == QW'(QUEUE_FRAMES - 1)) ? '0
                                                                          : head_reg + QW'(1);
                        count_next = count_reg - CW'(1);
                    end
                end
                else
                begin
                    pos_next = pos_reg + PW'(1);
                end
            end
            else
            begin
                if (ph == PH_SINE)
                begin
                    if (sine_len_reg != 16'd0)
                    begin
                        v         = 8'h00;
                        pcnt_next = pinc[15:0];
                        if (pinc >= 17'(sine_len_reg))
                        begin
                            phase_next = PH_ACQ;
                            pcnt_next  = 16'd0;
                        end
                    end
                    else
                    begin
                        ph   = PH_ACQ;
                        pinc = 17'd1;
                    end
                end
                if (ph == PH_ACQ)
                begin
                    // Falls through from a skipped sine phase on the same tick.
                    v          = BYTE_IDLE;
                    pcnt_next  = pinc[15:0];
                    phase_next = (pinc >= 17'(acq_len_reg)) ? PH_IDLE : PH_ACQ;
                end
                else if (ph == PH_IDLE && count_reg != '0)
                begin
                    v        = BYTE_SYNC0;
                    par_next = 8'h00;
                    pos_next = PW'(2);
                end
                else if (ph != PH_SINE)
                begin
                    v = BYTE_IDLE;
                end
            end
            res.out_byte = v;
        end
        else if (go && cmd.is_msg)
        begin
            mem_we    = !blk_eff && (fill_reg < 8'(PAY));
            fill_next = fill_inc;
            blk_next  = blk_eff;
            if (cmd.last_byte)
            begin
                if (blk_eff)
                begin
                    res.frame_dropped = 1'b1;
                end
                else
                begin
                    slot_wr    = 1'b1;
                    tail_next  = (tail_reg == QW'(QUEUE_FRAMES - 1)) ? '0 : tail_reg + QW'(1);
                    count_next = count_reg + CW'(1);
                end
                fill_next = 8'd0;
                blk_next  = 1'b0;
            end
        end
        else if (go && cmd.is_restart)
        begin
            if (pos_reg != '0)
            begin
                pos_next = '0;
                if (count_reg != '0)
                begin
                    head_next  = (head_reg == QW'(QUEUE_FRAMES - 1)) ? '0 : head_reg + QW'(1);
                    count_next = count_reg - CW'(1);
                end
            end
            phase_next = PH_SINE;
            pcnt_next  = 16'd0;
        end
        else if (go && cmd.is_off)
        begin
            phase_next = PH_OFF;
        end

        // Prefetch the payload byte that the next CLTU position will need.
        idx_n     = DW'(pos_next) - DW'(1);
        k_n       = idx_n - DW'(2);
        d_n       = DW'(k_n[DW-1:3]) * DW'(7) + DW'(k_n[2:0]) - DW'(3);
        mem_raddr = AW'(head_next) * AW'(PAY) + AW'(d_n);
    end

    tccf_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (cmd.data_byte),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (slot_wr)
        begin
            len_reg[tail_reg] <= fill_inc;
            cid_reg[tail_reg] <= craft_id_reg;
            ver_reg[tail_reg] <= version_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            craft_id_reg <= 16'd0;
            version_reg  <= 4'd0;
            rnd_reg      <= 1'b1;
            sine_len_reg <= 16'd0;
            acq_len_reg  <= 16'd0;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            fill_reg     <= 8'd0;
            blk_reg      <= 1'b0;
            phase_reg    <= PH_SINE;
            pcnt_reg     <= 16'd0;
            pos_reg      <= '0;
            par_reg      <= 8'd0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_CRAFT_ID:  craft_id_reg <= cfg_data;
                    REG_VERSION:   version_reg  <= cfg_data[3:0];
                    REG_RANDOMIZE: rnd_reg      <= cfg_data[0];
                    REG_SINE_LEN:  sine_len_reg <= cfg_data;
                    REG_ACQ_LEN:   acq_len_reg  <= cfg_data;
                    default:       ;
                endcase
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fill_reg  <= fill_next;
            blk_reg   <= blk_next;
            phase_reg <= phase_next;
            pcnt_reg  <= pcnt_next;
            pos_reg   <= pos_next;
            par_reg   <= par_next;
        end
    end

    tccf_fifo #(.WIDTH($bits(out_word_t))) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (go),
        .wdata (res),
        .rd    (pop),
        .rdata (result),
        .full  (out_full),
        .empty (empty)
    );
endmodule

// ===== sv/telecommand_cltu_framer_unit.sv =====
// Telecommand CLTU byte source with a small frame queue.
// Input words go in through a queue port: a word is taken when push is high
// and full is low. Each word carries an action: a tick that emits one uplink
// byte, a message byte, a restart of the start-up sequence, or off.
// Every input word produces exactly one result word, in order, on the result
// queue port: the oldest result sits on result while empty is low and leaves
// when pop is high. Ticks carry the sent byte with byte_valid set; the last
// byte of a message that could not be queued raises frame_dropped.
// Registers are written through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high, and writes are meant to happen while the block is idle.
// A word accepted at the input is decoded into a two-word command queue;
// the back end executes it from there and writes its result to the output
// queue, readable at once. Sustained rate is one word per clock while the
// output queue has room: the back end executes one word per cycle and the
// payload store is read one CLTU position ahead, so no bubble is ever needed.
// When the result side stalls, the output queue fills, the back end holds,
// then the command queue fills and full rises; nothing is lost.
// Reset clears all queues, empties the frame queue, sets randomization on and
// puts the link in the sine phase. The payload store itself is not cleared.
module telecommand_cltu_framer_unit #(
    parameter int FRAME_BYTES  = tccf_pkg::FRAME_BYTES_DEF,
    parameter int QUEUE_FRAMES = tccf_pkg::QUEUE_FRAMES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tccf_pkg::in_word_t  item,
    output logic                full,
    output logic                empty,
    input  logic                pop,
    output tccf_pkg::out_word_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import tccf_pkg::*;

    cmd_t cmd;
    logic cmd_empty, cmd_take;

    assign cfg_ready = 1'b1;

    tccf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .cmd_empty (cmd_empty)
    );

    tccf_back #(
        .FRAME_BYTES  (FRAME_BYTES),
        .QUEUE_FRAMES (QUEUE_FRAMES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_take  (cmd_take),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pop       (pop),
        .result    (result),
        .empty     (empty)
    );
endmodule
